// ===== rtl/pya_pkg.sv =====
// pya_pkg: shared types and constants of the priority yield arbiter
// item kinds, directive codes, register indexes, queue entry and control state
// no dependencies
package pya_pkg;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_CONFLICT = 2'd1,
		KIND_FINISH   = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_PROCEED = 2'd0,
		ACT_SLOW    = 2'd1,
		ACT_YIELD   = 2'd2
	} action_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ROSTER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_YIELD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HARD      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW      = 3'd5;

	localparam logic [8:0] SPEED_FULL   = 9'd256;
	localparam logic [4:0] RANK_BOOSTED = 5'd16;

	typedef struct packed {
		logic [4:0]  roster_count;
		logic [63:0] priority_ranks;
		logic [15:0] max_yield_ms;
		logic [15:0] cooldown_ms;
		logic [15:0] hard_yield_ms;
		logic [8:0]  slow_scale;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ms;
		logic [3:0]  agent_first;
		logic [3:0]  agent_second;
		logic [15:0] conflict_in_ms;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_START  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

// ===== rtl/pya_in_if.sv =====
// pya_in_if: input channel of the arbiter, valid/ready with one item payload
// no dependencies
interface pya_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] now_ms;
	logic [3:0]  agent_first;
	logic [3:0]  agent_second;
	logic [15:0] conflict_in_ms;

	modport source (output valid, kind, now_ms, agent_first, agent_second, conflict_in_ms,
		input ready);
	modport sink (input valid, kind, now_ms, agent_first, agent_second, conflict_in_ms,
		output ready);
endinterface

// ===== rtl/pya_out_if.sv =====
// pya_out_if: directive channel of the arbiter, valid/ready with one directive payload
// no dependencies
interface pya_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  agent;
	logic [1:0]  action;
	logic [8:0]  speed_factor;
	logic [3:0]  rival;
	logic [15:0] rival_in_ms;
	logic        boost_active;
	logic        last;

	modport source (output valid, agent, action, speed_factor, rival, rival_in_ms, boost_active,
		last, input ready);
	modport sink (input valid, agent, action, speed_factor, rival, rival_in_ms, boost_active,
		last, output ready);
endinterface

// ===== rtl/pya_front.sv =====
// pya_front: accepts item transactions, decodes the kind and holds them in a two-entry queue
// depends on pya_pkg and pya_in_if
module pya_front import pya_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pya_in_if.sink items,
	output cmd_t   cmd,
	output logic   cmd_valid,
	input  logic   cmd_pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       decoded;

	assign items.ready = (count_q != 2'd2);
	assign cmd_valid   = (count_q != 2'd0);
	assign cmd         = entry_q[rd_ptr_q];
	assign push        = items.valid && items.ready;
	assign pop         = cmd_pop && cmd_valid;

	always_comb begin
		decoded.kind           = kind_t'(items.kind);
		decoded.now_ms         = items.now_ms;
		decoded.agent_first    = items.agent_first;
		decoded.agent_second   = items.agent_second;
		decoded.conflict_in_ms = items.conflict_in_ms;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pya_back.sv =====
// pya_back: executes queued commands against the per-agent state, walks agents on start
// and finish transactions and drives the directive output register
// depends on pya_pkg and pya_out_if
module pya_back import pya_pkg::*; #(
	parameter int NUM_AGENTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	pya_out_if.source results
);

	localparam int AW = $clog2(NUM_AGENTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_AGENTS - 1);

	state_t      state_q;
	logic [AW-1:0] idx_q;
	logic [31:0] round_time_q;

	logic        yielding_q   [NUM_AGENTS];
	logic [31:0] yield_start_q[NUM_AGENTS];
	logic [31:0] boost_end_q  [NUM_AGENTS];
	logic        boosted_q    [NUM_AGENTS];
	action_t     ract_q       [NUM_AGENTS];
	logic [3:0]  rrival_q     [NUM_AGENTS];
	logic [15:0] rtime_q      [NUM_AGENTS];

	logic        out_valid_q;
	logic [3:0]  out_agent_q;
	action_t     out_action_q;
	logic [8:0]  out_speed_q;
	logic [3:0]  out_rival_q;
	logic [15:0] out_time_q;
	logic        out_boost_q;
	logic        out_last_q;

	logic [4:0]  roster_n;
	logic        out_free;
	logic        finish_step;
	logic        idx_last;

	logic [31:0] ys_cur;
	logic [31:0] elapsed;
	logic [32:0] end_sum;
	logic [31:0] end_sat;
	logic        earn;
	logic        boost_new;

	logic [3:0]  fa;
	logic [3:0]  fb;
	logic        pair_ok;
	logic [4:0]  eff_a;
	logic [4:0]  eff_b;
	logic [3:0]  loser;
	logic [3:0]  winner;
	logic [AW-1:0] lidx;

	logic [8:0]  slow_eff;
	logic [8:0]  speed_cur;

	assign roster_n = (cfg.roster_count > 5'(NUM_AGENTS)) ? 5'(NUM_AGENTS) : cfg.roster_count;
	assign out_free = !out_valid_q || results.ready;
	assign finish_step = (state_q == ST_FINISH) && out_free;
	assign idx_last = ((5'(idx_q) + 5'd1) == roster_n);
	assign cmd_pop = (state_q == ST_IDLE);

	// boost earning during the start walk
	assign ys_cur  = yield_start_q[idx_q];
	assign elapsed = round_time_q - ys_cur;
	assign end_sum = {1'b0, round_time_q} + 33'(cfg.cooldown_ms);
	assign end_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
	assign earn = (5'(idx_q) < roster_n) && yielding_q[idx_q] && (round_time_q >= ys_cur)
		&& (elapsed > 32'(cfg.max_yield_ms));
	assign boost_new = earn ? ((cfg.cooldown_ms != 16'd0) && (round_time_q != 32'hFFFF_FFFF))
		: (round_time_q < boost_end_q[idx_q]);

	// conflict resolution
	assign fa = cmd.agent_first;
	assign fb = cmd.agent_second;
	assign pair_ok = (5'(fa) < roster_n) && (5'(fb) < roster_n);
	assign eff_a = boosted_q[fa[AW-1:0]] ? RANK_BOOSTED
		: {1'b0, cfg.priority_ranks[{fa, 2'b00} +: 4]};
	assign eff_b = boosted_q[fb[AW-1:0]] ? RANK_BOOSTED
		: {1'b0, cfg.priority_ranks[{fb, 2'b00} +: 4]};
	assign loser  = (eff_a < eff_b) ? fa : fb;
	assign winner = (eff_a < eff_b) ? fb : fa;
	assign lidx   = loser[AW-1:0];

	assign slow_eff = (cfg.slow_scale > SPEED_FULL) ? SPEED_FULL : cfg.slow_scale;

	always_comb begin
		case (ract_q[idx_q])
			ACT_YIELD: speed_cur = 9'd0;
			ACT_SLOW:  speed_cur = slow_eff;
			default:   speed_cur = SPEED_FULL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			round_time_q <= 32'd0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_AGENTS; i++) begin
				yielding_q[i]    <= 1'b0;
				yield_start_q[i] <= 32'd0;
				boost_end_q[i]   <= 32'd0;
				boosted_q[i]     <= 1'b0;
				ract_q[i]        <= ACT_PROCEED;
				rrival_q[i]      <= 4'd0;
				rtime_q[i]       <= 16'd0;
			end
		end else begin
			if (finish_step) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_START: begin
								round_time_q <= cmd.now_ms;
								for (int i = 0; i < NUM_AGENTS; i++) begin
									ract_q[i]   <= ACT_PROCEED;
									rrival_q[i] <= 4'd0;
									rtime_q[i]  <= 16'd0;
								end
								idx_q   <= '0;
								state_q <= ST_START;
							end
							KIND_CONFLICT: begin
								if (pair_ok && (ract_q[lidx] != ACT_YIELD)) begin
									ract_q[lidx] <= (cmd.conflict_in_ms <= cfg.hard_yield_ms)
										? ACT_YIELD : ACT_SLOW;
									rrival_q[lidx] <= winner;
									rtime_q[lidx]  <= cmd.conflict_in_ms;
								end
							end
							KIND_FINISH: begin
								if (roster_n != 5'd0) begin
									idx_q   <= '0;
									state_q <= ST_FINISH;
								end
							end
							KIND_CLEAR: begin
								for (int i = 0; i < NUM_AGENTS; i++) begin
									yielding_q[i]    <= 1'b0;
									yield_start_q[i] <= 32'd0;
									boost_end_q[i]   <= 32'd0;
									boosted_q[i]     <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_START: begin
					if (earn) begin
						boost_end_q[idx_q] <= end_sat;
						yielding_q[idx_q]  <= 1'b0;
					end
					boosted_q[idx_q] <= boost_new;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (ract_q[idx_q] == ACT_YIELD) begin
							if (!yielding_q[idx_q]) begin
								yielding_q[idx_q]    <= 1'b1;
								yield_start_q[idx_q] <= round_time_q;
							end
						end else begin
							yielding_q[idx_q] <= 1'b0;
						end
						if (idx_last) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish_step) begin
			out_agent_q  <= 4'(idx_q);
			out_action_q <= ract_q[idx_q];
			out_speed_q  <= speed_cur;
			out_rival_q  <= rrival_q[idx_q];
			out_time_q   <= rtime_q[idx_q];
			out_boost_q  <= boosted_q[idx_q];
			out_last_q   <= idx_last;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.agent        = out_agent_q;
	assign results.action       = out_action_q;
	assign results.speed_factor = out_speed_q;
	assign results.rival        = out_rival_q;
	assign results.rival_in_ms  = out_time_q;
	assign results.boost_active = out_boost_q;
	assign results.last         = out_last_q;

endmodule

// ===== rtl/priority_yield_arbiter_with_aging.sv =====
// priority_yield_arbiter_with_aging: top level, configuration registers, front queue and executor
// a transaction waits in the two-entry queue until the idle executor pops it; conflict and
// clear are done in idle; start walks all NUM_AGENTS agents, one agent per cycle
// finish walks the roster, one directive per cycle while the output register is free
// reset: asynchronous, all timers, directives and boosts clear, registers take their defaults
// depends on pya_pkg, pya_in_if, pya_out_if, pya_front and pya_back
module priority_yield_arbiter_with_aging import pya_pkg::*; #(
	parameter int NUM_AGENTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pya_in_if.sink                items,
	pya_out_if.source             results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roster_count   <= 5'd16;
			cfg_q.priority_ranks <= 64'hFEDC_BA98_7654_3210;
			cfg_q.max_yield_ms   <= 16'd5000;
			cfg_q.cooldown_ms    <= 16'd3000;
			cfg_q.hard_yield_ms  <= 16'd1500;
			cfg_q.slow_scale     <= 9'd128;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROSTER:    cfg_q.roster_count   <= cfg_wdata[4:0];
				CFG_RANKS:     cfg_q.priority_ranks <= cfg_wdata;
				CFG_MAX_YIELD: cfg_q.max_yield_ms   <= cfg_wdata[15:0];
				CFG_COOLDOWN:  cfg_q.cooldown_ms    <= cfg_wdata[15:0];
				CFG_HARD:      cfg_q.hard_yield_ms  <= cfg_wdata[15:0];
				CFG_SLOW:      cfg_q.slow_scale     <= cfg_wdata[8:0];
				default: begin
				end
			endcase
		end
	end

	pya_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	pya_back #(
		.NUM_AGENTS (NUM_AGENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.results   (results)
	);

	a_yield_shape: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.action == ACT_YIELD)
		|-> (results.speed_factor == 9'd0))
		else $error("yield directive with nonzero speed");

	a_proceed_shape: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.action == ACT_PROCEED)
		|-> (results.speed_factor == SPEED_FULL) && (results.rival == 4'd0)
			&& (results.rival_in_ms == 16'd0))
		else $error("proceed directive carries a rival");

	a_agent_on_roster: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ({1'b0, results.agent} < cfg_q.roster_count)
			&& (int'(results.agent) < NUM_AGENTS))
		else $error("directive for an agent off the roster");

endmodule
